@@ src/frtg_pkg.sv @@
// shared types, constants and the tier settings table for the frame rate tier governor
`timescale 1ns / 1ps

package frtg_pkg;

  localparam int unsigned TimeW   = 24;
  localparam int unsigned FrameW  = 24;
  localparam int unsigned ScaledW = 44;  // holds (2^24-1) * 1e6
  localparam int unsigned ProdW   = 32;  // 8-bit fps times 24-bit time
  localparam int unsigned CountW  = 8;
  localparam int unsigned DeltaW  = 20;
  localparam int unsigned AddrW   = 5;

  localparam logic [TimeW-1:0]   TIME_MAX       = '1;
  localparam logic [FrameW-1:0]  FRAME_MAX      = '1;
  localparam logic [CountW-1:0]  COUNT_MAX      = '1;
  localparam logic [TimeW-1:0]   TINY_WINDOW_US = 24'd100;
  localparam logic [ScaledW-1:0] US_PER_S       = 44'd1000000;

  // tier codes
  localparam logic [1:0] TIER_LOW  = 2'd0;
  localparam logic [1:0] TIER_MED  = 2'd1;
  localparam logic [1:0] TIER_HIGH = 2'd2;

  // register indexes, byte address is 4 * index
  localparam logic [2:0] REG_INTERVAL  = 3'd0;
  localparam logic [2:0] REG_DOWNGRADE = 3'd1;
  localparam logic [2:0] REG_UPGRADE   = 3'd2;
  localparam logic [2:0] REG_SLOW_LIM  = 3'd3;
  localparam logic [2:0] REG_FAST_LIM  = 3'd4;

  typedef struct packed {
    logic [TimeW-1:0]  interval_us;
    logic [7:0]        downgrade_fps;
    logic [7:0]        upgrade_fps;
    logic [CountW-1:0] slow_limit;
    logic [CountW-1:0] fast_limit;
  } cfg_t;

  typedef struct packed {
    logic              judge;
    logic              slow;
    logic              fast;
    logic [CountW-1:0] slow_count;
    logic [CountW-1:0] fast_count;
    logic [1:0]        tier;
    logic [CountW-1:0] slow_limit;
    logic [CountW-1:0] fast_limit;
  } step_in_t;

  typedef struct packed {
    logic [CountW-1:0] slow_count;
    logic [CountW-1:0] fast_count;
    logic [1:0]        tier;
    logic              changed;
  } step_out_t;

  // result word, lowest field last
  typedef struct packed {
    logic       tier_changed;
    logic       window_done;
    logic [2:0] aa_level;
    logic [1:0] post_level;
    logic [1:0] foliage_level;
    logic [1:0] effects_level;
    logic [1:0] shadow_level;
    logic [1:0] view_distance_level;
    logic [6:0] screen_percent;
    logic [1:0] tier;
  } result_t;

  function automatic result_t tier_settings(input logic [1:0] tier, input logic done,
                                            input logic changed);
    result_t r;
    r.tier         = tier;
    r.aa_level     = 3'd4;
    r.window_done  = done;
    r.tier_changed = changed;
    unique case (tier)
      TIER_LOW: begin
        r.screen_percent      = 7'd78;
        r.view_distance_level = 2'd1;
        r.shadow_level        = 2'd0;
        r.effects_level       = 2'd1;
        r.foliage_level       = 2'd0;
        r.post_level          = 2'd1;
      end
      TIER_MED: begin
        r.screen_percent      = 7'd90;
        r.view_distance_level = 2'd2;
        r.shadow_level        = 2'd1;
        r.effects_level       = 2'd2;
        r.foliage_level       = 2'd1;
        r.post_level          = 2'd2;
      end
      default: begin
        r.screen_percent      = 7'd100;
        r.view_distance_level = 2'd3;
        r.shadow_level        = 2'd2;
        r.effects_level       = 2'd3;
        r.foliage_level       = 2'd2;
        r.post_level          = 2'd3;
      end
    endcase
    return r;
  endfunction

endpackage

@@ src/frame_rate_tier_governor.sv @@
// top level of the frame rate tier governor: window totals, rate products, tier update
//
//   port group      | dir | content
//   s_axis_*        | in  | frame tick word: delta_us
//   m_axis_*        | out | tier settings word per tick
//   apb (psel ...)  | in  | interval, fps thresholds, window limits
//
// one word accepted per cycle unless the output stalls, stage a loads at the accepting edge
// and stages b and c register the word in turn, stage c offering it on the output
// stage a adds the frame to the window totals, stage b forms the two fps*time
// products, stage c compares and updates the slow/fast counts and the tier
// each stage advances when the next one is empty or moving, so bubbles absorb a stalled output
// reset: tier high, totals and counts zero, registers at their defaults
`timescale 1ns / 1ps

module frame_rate_tier_governor (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [19:0] delta_us
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [1:0] tier, [8:2] screen_percent,
                                      // [10:9] view_distance_level, [12:11] shadow_level,
                                      // [14:13] effects_level, [16:15] foliage_level,
                                      // [18:17] post_level, [21:19] aa_level,
                                      // [22] window_done, [23] tier_changed
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  frtg_pkg::cfg_t cfg;

  frtg_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // window totals
  logic [frtg_pkg::TimeW-1:0]   time_q, time_d;
  logic [frtg_pkg::FrameW-1:0]  frame_q, frame_d;
  logic [frtg_pkg::ScaledW-1:0] scaled_q, scaled_d;   // frame_q * 1e6

  // stage registers
  logic                         a_valid_q, b_valid_q, c_valid_q;
  logic                         a_done_q, a_judge_q, b_done_q, b_judge_q;
  logic [frtg_pkg::TimeW-1:0]   a_time_q;
  logic [frtg_pkg::ScaledW-1:0] a_scaled_q, b_scaled_q;
  logic [frtg_pkg::ProdW-1:0]   b_down_q, b_up_q;
  frtg_pkg::result_t            c_word_q, c_word_d;

  // count and tier state
  logic [frtg_pkg::CountW-1:0]  slow_q, fast_q;
  logic [1:0]                   tier_q;

  logic                         a_ready, b_ready, c_ready;
  logic                         a_load, b_load, c_load;
  logic [frtg_pkg::TimeW:0]     time_sum;
  logic [frtg_pkg::TimeW-1:0]   time_new;
  logic                         frame_full;
  logic [frtg_pkg::ScaledW-1:0] scaled_new;
  logic                         close;
  frtg_pkg::step_in_t           step_in;
  frtg_pkg::step_out_t          step_out;

  assign c_ready = !c_valid_q || m_axis_tready;
  assign b_ready = !b_valid_q || c_ready;
  assign a_ready = !a_valid_q || b_ready;
  assign a_load  = s_axis_tvalid && a_ready;
  assign b_load  = a_valid_q && b_ready;
  assign c_load  = b_valid_q && c_ready;
  assign s_axis_tready = a_ready;

  // stage a: totals
  always_comb begin
    time_sum   = {1'b0, time_q} + {5'd0, s_axis_tdata[frtg_pkg::DeltaW-1:0]};
    time_new   = time_sum[frtg_pkg::TimeW] ? frtg_pkg::TIME_MAX
                                           : time_sum[frtg_pkg::TimeW-1:0];
    frame_full = (frame_q == frtg_pkg::FRAME_MAX);
    scaled_new = frame_full ? scaled_q : scaled_q + frtg_pkg::US_PER_S;
    close      = (time_new >= cfg.interval_us);
    if (close) begin
      time_d   = '0;
      frame_d  = '0;
      scaled_d = '0;
    end else begin
      time_d   = time_new;
      frame_d  = frame_full ? frame_q : frame_q + 24'd1;
      scaled_d = scaled_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_q   <= '0;
      frame_q  <= '0;
      scaled_q <= '0;
    end else if (a_load) begin
      time_q   <= time_d;
      frame_q  <= frame_d;
      scaled_q <= scaled_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_load) begin
      a_done_q   <= close;
      // frame count is never zero after the increment, so only the tiny window skips
      a_judge_q  <= close && (time_new > frtg_pkg::TINY_WINDOW_US);
      a_time_q   <= time_new;
      a_scaled_q <= scaled_new;
    end
  end

  // stage b: threshold times window time
  always_ff @(posedge clk_i) begin
    if (b_load) begin
      b_done_q   <= a_done_q;
      b_judge_q  <= a_judge_q;
      b_scaled_q <= a_scaled_q;
      b_down_q   <= 32'(cfg.downgrade_fps) * 32'(a_time_q);
      b_up_q     <= 32'(cfg.upgrade_fps) * 32'(a_time_q);
    end
  end

  // stage c: judgement, counts, tier
  always_comb begin
    step_in.judge      = b_judge_q;
    step_in.slow       = (b_scaled_q < 44'(b_down_q));
    step_in.fast       = (b_scaled_q > 44'(b_up_q));
    step_in.slow_count = slow_q;
    step_in.fast_count = fast_q;
    step_in.tier       = tier_q;
    step_in.slow_limit = cfg.slow_limit;
    step_in.fast_limit = cfg.fast_limit;
  end

  frtg_tier_step u_step (
    .step_i (step_in),
    .step_o (step_out)
  );

  assign c_word_d = frtg_pkg::tier_settings(step_out.tier, b_done_q, step_out.changed);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slow_q <= '0;
      fast_q <= '0;
      tier_q <= frtg_pkg::TIER_HIGH;
    end else if (c_load) begin
      slow_q <= step_out.slow_count;
      fast_q <= step_out.fast_count;
      tier_q <= step_out.tier;
    end
  end

  always_ff @(posedge clk_i) begin
    if (c_load) begin
      c_word_q <= c_word_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
    end else begin
      if (a_ready) a_valid_q <= s_axis_tvalid;
      if (b_ready) b_valid_q <= a_valid_q;
      if (c_ready) c_valid_q <= b_valid_q;
    end
  end

  assign m_axis_tvalid = c_valid_q;
  assign m_axis_tdata  = c_word_q;

  // tier moves only when a word enters the output stage
  assert property (@(posedge clk_i) disable iff (!rst_ni) !c_load |=> $stable(tier_q))
    else $error("tier moved without a word entering the output stage");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (a_load && close) |=> (time_q == '0 && frame_q == '0))
    else $error("window totals not cleared after close");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (frame_q == '0) |-> (scaled_q == '0))
    else $error("scaled frame total out of step with frame total");

  assert property (@(posedge clk_i) disable iff (!rst_ni) !(slow_q != '0 && fast_q != '0))
    else $error("slow and fast counts both nonzero");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (m_axis_tvalid && c_word_q.tier_changed) |-> c_word_q.window_done)
    else $error("tier changed on a tick that closed no window");

endmodule

@@ src/frtg_regs.sv @@
// apb register file holding the governor configuration
`timescale 1ns / 1ps

module frtg_regs (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [frtg_pkg::AddrW-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  output frtg_pkg::cfg_t            cfg_o
);

  frtg_pkg::cfg_t cfg_q;
  logic           wr_en;
  logic [2:0]     idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = paddr[4:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.interval_us   <= 24'd1000000;
      cfg_q.downgrade_fps <= 8'd25;
      cfg_q.upgrade_fps   <= 8'd55;
      cfg_q.slow_limit    <= 8'd2;
      cfg_q.fast_limit    <= 8'd3;
    end else if (wr_en) begin
      unique case (idx)
        frtg_pkg::REG_INTERVAL:  cfg_q.interval_us   <= pwdata[23:0];
        frtg_pkg::REG_DOWNGRADE: cfg_q.downgrade_fps <= pwdata[7:0];
        frtg_pkg::REG_UPGRADE:   cfg_q.upgrade_fps   <= pwdata[7:0];
        frtg_pkg::REG_SLOW_LIM:  cfg_q.slow_limit    <= pwdata[7:0];
        frtg_pkg::REG_FAST_LIM:  cfg_q.fast_limit    <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      frtg_pkg::REG_INTERVAL:  prdata = {8'd0, cfg_q.interval_us};
      frtg_pkg::REG_DOWNGRADE: prdata = {24'd0, cfg_q.downgrade_fps};
      frtg_pkg::REG_UPGRADE:   prdata = {24'd0, cfg_q.upgrade_fps};
      frtg_pkg::REG_SLOW_LIM:  prdata = {24'd0, cfg_q.slow_limit};
      frtg_pkg::REG_FAST_LIM:  prdata = {24'd0, cfg_q.fast_limit};
      default:                 prdata = 32'd0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

@@ src/frtg_tier_step.sv @@
// count update and tier stepping for one judged window
`timescale 1ns / 1ps

module frtg_tier_step (
  input  frtg_pkg::step_in_t  step_i,
  output frtg_pkg::step_out_t step_o
);

  logic [frtg_pkg::CountW-1:0] slow_n;
  logic [frtg_pkg::CountW-1:0] fast_n;
  logic [1:0]                  tier_n;

  always_comb begin
    slow_n = step_i.slow_count;
    fast_n = step_i.fast_count;
    tier_n = step_i.tier;
    if (step_i.judge) begin
      priority if (step_i.slow) begin
        slow_n = (step_i.slow_count == frtg_pkg::COUNT_MAX) ? frtg_pkg::COUNT_MAX
                                                            : step_i.slow_count + 8'd1;
        fast_n = '0;
      end else if (step_i.fast) begin
        fast_n = (step_i.fast_count == frtg_pkg::COUNT_MAX) ? frtg_pkg::COUNT_MAX
                                                            : step_i.fast_count + 8'd1;
        slow_n = '0;
      end else begin
        slow_n = '0;
        fast_n = '0;
      end
      // slow wins when both limits are met
      priority if (slow_n >= step_i.slow_limit) begin
        if (step_i.tier == frtg_pkg::TIER_HIGH || step_i.tier == frtg_pkg::TIER_MED) begin
          tier_n = step_i.tier - 2'd1;
        end
        slow_n = '0;
      end else if (fast_n >= step_i.fast_limit) begin
        if (step_i.tier == frtg_pkg::TIER_LOW || step_i.tier == frtg_pkg::TIER_MED) begin
          tier_n = step_i.tier + 2'd1;
        end
        fast_n = '0;
      end
    end
  end

  assign step_o.slow_count = slow_n;
  assign step_o.fast_count = fast_n;
  assign step_o.tier       = tier_n;
  assign step_o.changed    = (tier_n != step_i.tier);

endmodule

@@ sim/tb.sv @@
// testbench for the frame rate tier governor: directed table, random windows, checked per word
`timescale 1ns / 1ps

module tb;

  localparam int unsigned PHASES       = 12;
  localparam int unsigned PHASE_ITEMS  = 105;
  localparam int unsigned HOLD_CYCLES  = 60;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned LIMIT_CYCLES = 300000;

  // directed words whose result is plain from the tier table
  localparam frtg_pkg::result_t HIGH_QUIET = '{
    tier_changed: 1'b0, window_done: 1'b0, aa_level: 3'd4,
    post_level: 2'd3, foliage_level: 2'd2, effects_level: 2'd3,
    shadow_level: 2'd2, view_distance_level: 2'd3,
    screen_percent: 7'd100, tier: frtg_pkg::TIER_HIGH};
  localparam frtg_pkg::result_t HIGH_WINDOW = '{
    tier_changed: 1'b0, window_done: 1'b1, aa_level: 3'd4,
    post_level: 2'd3, foliage_level: 2'd2, effects_level: 2'd3,
    shadow_level: 2'd2, view_distance_level: 2'd3,
    screen_percent: 7'd100, tier: frtg_pkg::TIER_HIGH};
  localparam frtg_pkg::result_t MED_STEP = '{
    tier_changed: 1'b1, window_done: 1'b1, aa_level: 3'd4,
    post_level: 2'd2, foliage_level: 2'd1, effects_level: 2'd2,
    shadow_level: 2'd1, view_distance_level: 2'd2,
    screen_percent: 7'd90, tier: frtg_pkg::TIER_MED};
  localparam frtg_pkg::result_t LOW_WINDOW = '{
    tier_changed: 1'b0, window_done: 1'b1, aa_level: 3'd4,
    post_level: 2'd1, foliage_level: 2'd0, effects_level: 2'd1,
    shadow_level: 2'd0, view_distance_level: 2'd1,
    screen_percent: 7'd78, tier: frtg_pkg::TIER_LOW};

  typedef struct {
    bit                is_cfg;
    logic [2:0]        idx;
    logic [31:0]       value;
    logic [19:0]       delta;
    bit                typed;
    frtg_pkg::result_t want;
  } plan_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // sideband that travels with each driven word
  bit                tick_typed;
  frtg_pkg::result_t tick_want;

  // predicted register file
  logic [23:0] c_interval;
  logic [7:0]  c_downgrade;
  logic [7:0]  c_upgrade;
  logic [7:0]  c_slow_lim;
  logic [7:0]  c_fast_lim;

  // predicted window state
  logic [23:0] g_time;
  logic [23:0] g_frames;
  logic [7:0]  g_slow;
  logic [7:0]  g_fast;
  logic [1:0]  g_tier;

  frtg_pkg::result_t settings_due[$];
  plan_row_t         plan[$];
  int unsigned       errors;
  int unsigned       cycles;
  bit                calm;
  bit                hold_pending;

  frame_rate_tier_governor dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic frtg_pkg::result_t tier_levels(input logic [1:0] code, input logic done,
                                                    input logic moved);
    frtg_pkg::result_t r;
    logic [1:0]        t;
    t = (code == frtg_pkg::TIER_LOW || code == frtg_pkg::TIER_MED) ? code
                                                                   : frtg_pkg::TIER_HIGH;
    case (t)
      frtg_pkg::TIER_LOW: r.screen_percent = 7'd78;
      frtg_pkg::TIER_MED: r.screen_percent = 7'd90;
      default:            r.screen_percent = 7'd100;
    endcase
    r.tier                = code;
    r.view_distance_level = t + 2'd1;
    r.shadow_level        = t;
    r.effects_level       = t + 2'd1;
    r.foliage_level       = t;
    r.post_level          = t + 2'd1;
    r.aa_level            = 3'd4;
    r.window_done         = done;
    r.tier_changed        = moved;
    return r;
  endfunction

  // one frame tick: add to the window, judge it when it closes, step the tier
  task automatic governor_step(input logic [19:0] delta, output frtg_pkg::result_t res);
    logic [24:0] sum;
    logic [63:0] scaled;
    logic [63:0] slow_bar;
    logic [63:0] fast_bar;
    logic [1:0]  old_tier;
    logic        done;
    sum = {1'b0, g_time} + 25'(delta);
    g_time = (sum > {1'b0, frtg_pkg::TIME_MAX}) ? frtg_pkg::TIME_MAX : sum[23:0];
    if (g_frames != frtg_pkg::FRAME_MAX) g_frames = g_frames + 24'd1;
    done = (g_time >= c_interval);
    old_tier = g_tier;
    if (done) begin
      // tiny windows close without a judgement
      if (g_time > frtg_pkg::TINY_WINDOW_US && g_frames != '0) begin
        scaled   = 64'(g_frames) * 64'd1000000;
        slow_bar = 64'(c_downgrade) * 64'(g_time);
        fast_bar = 64'(c_upgrade) * 64'(g_time);
        if (scaled < slow_bar) begin
          g_slow = (g_slow == frtg_pkg::COUNT_MAX) ? frtg_pkg::COUNT_MAX : g_slow + 8'd1;
          g_fast = '0;
        end else if (scaled > fast_bar) begin
          g_fast = (g_fast == frtg_pkg::COUNT_MAX) ? frtg_pkg::COUNT_MAX : g_fast + 8'd1;
          g_slow = '0;
        end else begin
          g_slow = '0;
          g_fast = '0;
        end
        if (g_slow >= c_slow_lim) begin
          if (g_tier == frtg_pkg::TIER_HIGH || g_tier == frtg_pkg::TIER_MED) begin
            g_tier = g_tier - 2'd1;
          end
          g_slow = '0;
        end else if (g_fast >= c_fast_lim) begin
          if (g_tier == frtg_pkg::TIER_LOW || g_tier == frtg_pkg::TIER_MED) begin
            g_tier = g_tier + 2'd1;
          end
          g_fast = '0;
        end
      end
      g_time   = '0;
      g_frames = '0;
    end
    res = tier_levels(g_tier, done, g_tier != old_tier);
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
    end
  endtask

  task automatic check_word(input frtg_pkg::result_t want, input frtg_pkg::result_t got);
    check_field("tier", want.tier, got.tier);
    check_field("screen_percent", want.screen_percent, got.screen_percent);
    check_field("view_distance_level", want.view_distance_level, got.view_distance_level);
    check_field("shadow_level", want.shadow_level, got.shadow_level);
    check_field("effects_level", want.effects_level, got.effects_level);
    check_field("foliage_level", want.foliage_level, got.foliage_level);
    check_field("post_level", want.post_level, got.post_level);
    check_field("aa_level", want.aa_level, got.aa_level);
    check_field("window_done", want.window_done, got.window_done);
    check_field("tier_changed", want.tier_changed, got.tier_changed);
  endtask

  // input and output words are both handled here so that order within an edge is fixed
  always @(posedge clk_i) begin
    frtg_pkg::result_t want;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        governor_step(s_axis_tdata[19:0], want);
        settings_due.push_back(tick_typed ? tick_want : want);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (settings_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected word, expected none actual %h", $time, m_axis_tdata);
        end else begin
          check_word(settings_due.pop_front(), frtg_pkg::result_t'(m_axis_tdata));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= LIMIT_CYCLES) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // output side: random stalls, plus one long hold-off on request
  initial begin
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_pending) begin
        hold_pending = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic send_tick(input logic [19:0] delta, input bit typed,
                           input frtg_pkg::result_t want);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'h0, delta};
    tick_typed    <= typed;
    tick_want     <= want;
    do @(posedge clk_i); while (!s_axis_tready);
    if (!calm && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
  endtask

  // stop offering words and wait until every expected word is back
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (settings_due.size() != 0);
  endtask

  // write, then read back in a back-to-back transfer
  task automatic write_register(input logic [2:0] idx, input logic [31:0] value);
    logic [31:0] kept;
    drain_results();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    case (idx)
      frtg_pkg::REG_INTERVAL: begin
        c_interval = value[23:0];
        kept = {8'h0, value[23:0]};
      end
      frtg_pkg::REG_DOWNGRADE: begin
        c_downgrade = value[7:0];
        kept = {24'h0, value[7:0]};
      end
      frtg_pkg::REG_UPGRADE: begin
        c_upgrade = value[7:0];
        kept = {24'h0, value[7:0]};
      end
      frtg_pkg::REG_SLOW_LIM: begin
        c_slow_lim = value[7:0];
        kept = {24'h0, value[7:0]};
      end
      default: begin
        c_fast_lim = value[7:0];
        kept = {24'h0, value[7:0]};
      end
    endcase
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata !== kept) begin
      errors++;
      $display("%0t: register %0d readback, expected %h actual %h", $time, idx, kept, prdata);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic add_tick(input logic [19:0] delta, input bit typed,
                          input frtg_pkg::result_t want);
    plan_row_t r;
    r.is_cfg = 1'b0;
    r.idx    = '0;
    r.value  = '0;
    r.delta  = delta;
    r.typed  = typed;
    r.want   = want;
    plan.push_back(r);
  endtask

  task automatic add_cfg(input logic [2:0] idx, input logic [31:0] value);
    plan_row_t r;
    r.is_cfg = 1'b1;
    r.idx    = idx;
    r.value  = value;
    r.delta  = '0;
    r.typed  = 1'b0;
    r.want   = '0;
    plan.push_back(r);
  endtask

  // random upper bits now and then, the register keeps only its own width
  function automatic logic [31:0] with_noise(input logic [31:0] field, input logic [31:0] mask);
    logic [31:0] upper;
    upper = ($urandom_range(0, 3) == 0) ? $urandom() : 32'h0;
    return (upper & ~mask) | (field & mask);
  endfunction

  function automatic logic [7:0] pick_limit();
    if ($urandom_range(0, 3) == 0) return ($urandom_range(0, 1) != 0) ? 8'd255 : 8'd0;
    return 8'($urandom_range(1, 4));
  endfunction

  initial begin
    logic [23:0] interval;
    logic [19:0] delta;
    int unsigned target_fps;
    int unsigned base;
    bit          long_frames;

    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    tick_typed    <= 1'b0;
    tick_want     <= '0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    errors        = 0;
    cycles        = 0;
    calm          = 1'b0;
    hold_pending  = 1'b0;
    c_interval    = 24'd1000000;
    c_downgrade   = 8'd25;
    c_upgrade     = 8'd55;
    c_slow_lim    = 8'd2;
    c_fast_lim    = 8'd3;
    g_time        = '0;
    g_frames      = '0;
    g_slow        = '0;
    g_fast        = '0;
    g_tier        = frtg_pkg::TIER_HIGH;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: long frames walk the tier down to low and hold it there
    add_tick(20'h0, 1'b1, HIGH_QUIET);
    add_tick(20'hFFFFF, 1'b1, HIGH_WINDOW);
    add_tick(20'hFFFFF, 1'b1, MED_STEP);
    repeat (4) add_tick(20'hFFFFF, 1'b0, '0);
    // tiny window: closes but is not judged
    add_cfg(frtg_pkg::REG_INTERVAL, 32'd100);
    add_tick(20'd100, 1'b1, LOW_WINDOW);
    // zero interval, upper bits must be dropped
    add_cfg(frtg_pkg::REG_INTERVAL, 32'hFF00_0000);
    add_tick(20'h0, 1'b1, LOW_WINDOW);
    repeat (3) add_tick(20'd200, 1'b0, '0);
    // zero limits: slow step wins even on a fast window
    add_cfg(frtg_pkg::REG_SLOW_LIM, 32'h0);
    add_cfg(frtg_pkg::REG_FAST_LIM, 32'h0);
    add_tick(20'd200, 1'b0, '0);
    add_cfg(frtg_pkg::REG_DOWNGRADE, 32'h0);
    add_cfg(frtg_pkg::REG_UPGRADE, 32'h0);
    add_tick(20'd200, 1'b0, '0);
    add_cfg(frtg_pkg::REG_DOWNGRADE, 32'hFFFF_FFFF);
    add_cfg(frtg_pkg::REG_UPGRADE, 32'd255);
    add_cfg(frtg_pkg::REG_SLOW_LIM, 32'd255);
    add_cfg(frtg_pkg::REG_FAST_LIM, 32'd1);
    add_tick(20'd200, 1'b0, '0);
    add_tick(20'd5000, 1'b0, '0);
    add_tick(20'hFFFFF, 1'b0, '0);
    add_tick(20'd4000, 1'b0, '0);
    add_cfg(frtg_pkg::REG_INTERVAL, 32'hFFFF_FFFF);
    add_tick(20'd1, 1'b0, '0);
    add_tick(20'h55555, 1'b0, '0);
    add_tick(20'hAAAAA, 1'b0, '0);

    foreach (plan[i]) begin
      if (plan[i].is_cfg) write_register(plan[i].idx, plan[i].value);
      else send_tick(plan[i].delta, plan[i].typed, plan[i].want);
    end

    target_fps = 40;
    for (int unsigned p = 0; p < PHASES; p++) begin
      // first phase runs the window to the top so the time total saturates
      long_frames = (p == 0);
      case ($urandom_range(0, 5))
        0:       interval = 24'd0;
        1:       interval = 24'($urandom_range(1, 300));
        2:       interval = 24'($urandom_range(1000, 50000));
        5:       interval = 24'hFFFFFF;
        default: interval = 24'($urandom_range(50000, 300000));
      endcase
      if (long_frames) interval = 24'hFFFFFF;
      write_register(frtg_pkg::REG_INTERVAL, with_noise({8'h0, interval}, 32'h00FF_FFFF));
      write_register(frtg_pkg::REG_DOWNGRADE, with_noise(($urandom_range(0, 3) == 0) ?
                     32'($urandom_range(0, 1) * 255) : 32'($urandom_range(10, 40)), 32'hFF));
      write_register(frtg_pkg::REG_UPGRADE, with_noise(($urandom_range(0, 3) == 0) ?
                     32'($urandom_range(0, 1) * 255) : 32'($urandom_range(40, 90)), 32'hFF));
      write_register(frtg_pkg::REG_SLOW_LIM, with_noise({24'h0, pick_limit()}, 32'hFF));
      write_register(frtg_pkg::REG_FAST_LIM, with_noise({24'h0, pick_limit()}, 32'hFF));
      calm = (p == PHASES - 1);

      for (int unsigned n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 3 && n == 10) hold_pending = 1'b1;
        if (p == 5 && n == 50) drain_results();
        // frame times follow a drifting rate so windows land slow, fast and in between
        if ($urandom_range(0, 19) == 0) target_fps = $urandom_range(5, 150);
        base = 1000000 / target_fps;
        if (long_frames) begin
          delta = 20'($urandom_range(800000, 20'hFFFFF));
        end else if ($urandom_range(0, 99) < 85) begin
          delta = 20'(base - base / 8 + $urandom_range(0, base / 4));
        end else begin
          case ($urandom_range(0, 3))
            0:       delta = 20'h0;
            1:       delta = 20'hFFFFF;
            2:       delta = 20'($urandom_range(0, 100));
            default: delta = 20'($urandom_range(0, 20'hFFFFF));
          endcase
        end
        send_tick(delta, 1'b0, '0);
      end
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ frame_rate_tier_governor.f @@
src/frtg_pkg.sv
src/frtg_regs.sv
src/frtg_tier_step.sv
src/frame_rate_tier_governor.sv
sim/tb.sv
